// File: design/ccks_pkg.sv
// Shared types, constants and functions for the ChaCha20 keystream generator.
// Depends on nothing; every other file in design/ refers to it by scoped name.
package ccks_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [3:0][31:0]  quad_t;
  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0]  key_t;
  typedef logic [2:0][31:0]  nonce_t;

  // Largest number of bytes one block can give
  localparam int BlkBytes = 64;
  // Entries in the queue between front and back
  localparam int QDepth   = 2;

  // "expand 32-byte k"
  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646E;
  localparam word_t Sigma2 = 32'h7962_2D32;
  localparam word_t Sigma3 = 32'h6B20_6574;

  // One block job as handed from front to back
  typedef struct packed {
    logic [6:0] want;
    word_t      ctr;
    nonce_t     nonce;
  } job_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Quarter round on words a, b, c, d (elements 0..3 of q)
  function automatic quad_t qround(quad_t q);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    quad_t r;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  function automatic blk_t apply_qr(blk_t s, logic [3:0] ia, logic [3:0] ib,
                                    logic [3:0] ic, logic [3:0] id);
    quad_t q;
    blk_t  r;
    r    = s;
    q[0] = s[ia];
    q[1] = s[ib];
    q[2] = s[ic];
    q[3] = s[id];
    q    = qround(q);
    r[ia] = q[0];
    r[ib] = q[1];
    r[ic] = q[2];
    r[id] = q[3];
    return r;
  endfunction

  // Column round: four independent quarter rounds
  function automatic blk_t col_round(blk_t s);
    blk_t r;
    r = apply_qr(s, 4'd0, 4'd4, 4'd8,  4'd12);
    r = apply_qr(r, 4'd1, 4'd5, 4'd9,  4'd13);
    r = apply_qr(r, 4'd2, 4'd6, 4'd10, 4'd14);
    r = apply_qr(r, 4'd3, 4'd7, 4'd11, 4'd15);
    return r;
  endfunction

  // Diagonal round: four independent quarter rounds
  function automatic blk_t diag_round(blk_t s);
    blk_t r;
    r = apply_qr(s, 4'd0, 4'd5, 4'd10, 4'd15);
    r = apply_qr(r, 4'd1, 4'd6, 4'd11, 4'd12);
    r = apply_qr(r, 4'd2, 4'd7, 4'd8,  4'd13);
    r = apply_qr(r, 4'd3, 4'd4, 4'd9,  4'd14);
    return r;
  endfunction

  // Initial block state from key, counter and nonce
  function automatic blk_t init_block(key_t key, word_t ctr, nonce_t nonce);
    blk_t r;
    r[0] = Sigma0;
    r[1] = Sigma1;
    r[2] = Sigma2;
    r[3] = Sigma3;
    for (int i = 0; i < 8; i++) begin
      r[4 + i] = key[i];
    end
    r[12] = ctr;
    r[13] = nonce[0];
    r[14] = nonce[1];
    r[15] = nonce[2];
    return r;
  endfunction

  // Zero the bytes above the wanted ones
  function automatic word_t mask_word(word_t w, logic [2:0] vb);
    word_t r;
    case (vb)
      3'd1:    r = {24'h0, w[7:0]};
      3'd2:    r = {16'h0, w[15:0]};
      3'd3:    r = {8'h0, w[23:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// File: design/ccks_queue.sv
// Short FIFO of block jobs between the front and the back.
// Depends on ccks_pkg (job_t, QDepth).
module ccks_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ccks_pkg::job_t   push_job,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output ccks_pkg::job_t   pop_job
);

  localparam int PtrW = (ccks_pkg::QDepth > 1) ? $clog2(ccks_pkg::QDepth) : 1;
  localparam int CntW = $clog2(ccks_pkg::QDepth + 1);

  ccks_pkg::job_t  mem_r [ccks_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full      = (cnt_r == CntW'(ccks_pkg::QDepth));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(ccks_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(ccks_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/ccks_front.sv
// Front end: takes request words, clamps the byte count, tracks counter and nonce.
// Depends on ccks_pkg (job_t, BlkBytes); feeds ccks_queue.
module ccks_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [6:0]       in_block_bytes,
  input  logic             in_end_of_request,
  input  logic             q_full,
  output logic             q_push,
  output ccks_pkg::job_t   q_job
);

  ccks_pkg::word_t  ctr_r, ctr_nxt;
  logic [95:0]      nonce_r, nonce_nxt;
  logic [6:0]       want_sat;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // clamp to one full block
  assign want_sat = (in_block_bytes > 7'(ccks_pkg::BlkBytes)) ?
                    7'(ccks_pkg::BlkBytes) : in_block_bytes;

  // a block with no wanted bytes is counted but never queued
  assign q_push      = accept && (want_sat != '0);
  assign q_job.want  = want_sat;
  assign q_job.ctr   = ctr_r;
  assign q_job.nonce = nonce_r;

  // counter steps per block; end of request clears it and steps the nonce
  always_comb begin
    ctr_nxt   = ctr_r;
    nonce_nxt = nonce_r;
    if (accept) begin
      if (in_end_of_request) begin
        ctr_nxt   = '0;
        nonce_nxt = nonce_r + 96'd1;
      end else begin
        ctr_nxt = ctr_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r   <= '0;
      nonce_r <= '0;
    end else begin
      ctr_r   <= ctr_nxt;
      nonce_r <= nonce_nxt;
    end
  end

endmodule

// File: design/ccks_core.sv
// Back end: key registers, round engine (one round per cycle), final add and
// word output register. Depends on ccks_pkg.
module ccks_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  logic             job_valid,
  input  ccks_pkg::job_t   job,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_word,
  output logic [2:0]       out_valid_bytes,
  output logic             out_last
);

  localparam int Rounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW   = $clog2(Rounds);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_ADD   = 4'b0100,
    S_EMIT  = 4'b1000
  } core_st_t;

  core_st_t          st_r, st_nxt;
  logic [RndW-1:0]   rnd_r, rnd_nxt;
  ccks_pkg::key_t    key_r;
  ccks_pkg::blk_t    blk_r;
  ccks_pkg::word_t   ctr_r;
  ccks_pkg::nonce_t  nonce_r;
  logic [6:0]        rem_r;
  logic [3:0]        k_r;
  logic              out_valid_r;
  ccks_pkg::word_t   out_word_r;
  logic [2:0]        out_vb_r;
  logic              out_last_r;

  ccks_pkg::blk_t    init_blk;
  ccks_pkg::blk_t    round_blk;
  logic [2:0]        vb;
  logic              is_last;
  logic              emit_fire;
  logic              last_round;

  assign init_blk   = ccks_pkg::init_block(key_r, ctr_r, nonce_r);
  // even rounds work on columns, odd rounds on diagonals
  assign round_blk  = rnd_r[0] ? ccks_pkg::diag_round(blk_r) : ccks_pkg::col_round(blk_r);
  assign last_round = (rnd_r == RndW'(Rounds - 1));

  assign vb        = (rem_r > 7'd4) ? 3'd4 : rem_r[2:0];
  assign is_last   = (rem_r <= 7'd4);
  assign emit_fire = (st_r == S_EMIT) && (!out_valid_r || out_ready);
  assign job_pop   = (st_r == S_IDLE) && job_valid;

  // sequencer
  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          st_nxt  = S_ROUND;
          rnd_nxt = '0;
        end
      end
      S_ROUND: begin
        rnd_nxt = rnd_r + 1'b1;
        if (last_round) begin
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire && is_last) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // key registers: two key words per write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[{cfg_index, 1'b0}] <= cfg_wdata[31:0];
      key_r[{cfg_index, 1'b1}] <= cfg_wdata[63:32];
    end
  end

  // block state, job capture and word output register
  always_ff @(posedge clk) begin
    if (job_pop) begin
      ctr_r   <= job.ctr;
      nonce_r <= job.nonce;
      rem_r   <= job.want;
      blk_r   <= ccks_pkg::init_block(key_r, job.ctr, job.nonce);
    end
    if (st_r == S_ROUND) begin
      blk_r <= round_blk;
    end
    if (st_r == S_ADD) begin
      for (int i = 0; i < 16; i++) begin
        blk_r[i] <= blk_r[i] + init_blk[i];
      end
      k_r <= '0;
    end
    if (emit_fire) begin
      out_word_r <= ccks_pkg::mask_word(blk_r[k_r], vb);
      out_vb_r   <= vb;
      out_last_r <= is_last;
      rem_r      <= rem_r - 7'd4;
      k_r        <= k_r + 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last        = out_last_r;

endmodule

// File: design/chacha20_keystream_generator.sv
// Top level of the ChaCha20 keystream generator: front end, job queue, back end.
// Depends on ccks_pkg, ccks_front, ccks_queue and ccks_core.
//
// Each input word asks for one 64-byte ChaCha20 block (256-bit key written
// through cfg_*, 32-bit block counter, 96-bit nonce) of which the first
// in_block_bytes bytes (clamped to 64) leave as little-endian 32-bit words,
// the final one flagged with out_last and unwanted bytes zeroed. The counter
// steps per block and restarts at zero after a block marked end of request,
// when the nonce steps by one. A request of zero bytes is counted but gives
// no word. The front end counts and queues blocks, so it keeps accepting
// while the back end works, up to two queued blocks. The back end runs one
// round (column or diagonal) per cycle on a single round unit. Each block
// passes job pickup, the rounds and the final add; its words then leave in
// order, held back while out_ready is low, and the next block is picked up
// only after its last word. Key writes must be made only while no block is
// in flight.
module chacha20_keystream_generator #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_block_bytes,
  input  logic        in_end_of_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last
);

  logic            q_full;
  logic            q_push;
  ccks_pkg::job_t  q_push_job;
  logic            q_pop;
  logic            q_valid;
  ccks_pkg::job_t  q_pop_job;

  // request intake
  ccks_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_block_bytes    (in_block_bytes),
    .in_end_of_request (in_end_of_request),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (q_push_job)
  );

  // block job queue
  ccks_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_pop_job)
  );

  // block computation and word output
  ccks_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .job_valid       (q_valid),
    .job             (q_pop_job),
    .job_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last)
  );

`ifndef ASSERT_OFF
  // byte count of a word stays within one to four
  a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes != 3'd0) && (out_valid_bytes <= 3'd4))
    else $error("word byte count out of range");

  // a short word can only close a block
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_valid_bytes != 3'd4)) |-> out_last)
    else $error("short word not marked last");

  // unwanted bytes of a one-byte word are zero
  a_mask_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_valid_bytes == 3'd1)) |-> (out_word[31:8] == 24'h0))
    else $error("unwanted bytes not cleared");

  // no job is taken from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job taken from empty queue");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for chacha20_keystream_generator: queued stimulus, a clocked driver and
// monitor, and a block-function predictor that scores every keystream word.
// Depends only on design/chacha20_keystream_generator.sv and the files it pulls in.
module testbench;

  localparam int N_DOUBLE_ROUNDS = 10;
  localparam int IDLE_PCT        = 22;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 150;
  localparam int MAX_WANT        = 64;

  // Key register indexes
  localparam bit [1:0] REG_KEY_01 = 2'd0;
  localparam bit [1:0] REG_KEY_23 = 2'd1;
  localparam bit [1:0] REG_KEY_45 = 2'd2;
  localparam bit [1:0] REG_KEY_67 = 2'd3;

  // "expand 32-byte k"
  localparam bit [31:0] EXPAND_0 = 32'h6170_7865;
  localparam bit [31:0] EXPAND_1 = 32'h3320_646E;
  localparam bit [31:0] EXPAND_2 = 32'h7962_2D32;
  localparam bit [31:0] EXPAND_3 = 32'h6B20_6574;

  typedef bit [31:0] ks_state_t [16];

  typedef struct {
    bit [6:0] nbytes;
    bit       eor;
  } block_req_t;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  nbytes;
    bit        last;
  } ks_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [6:0]  in_block_bytes = '0;
  logic        in_end_of_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last;

  // Predictor state
  bit [31:0] key_model [8];
  bit [31:0] ctr_model;
  bit [31:0] nonce_model [3];

  block_req_t pending_blocks [$];
  ks_word_t   expected_words [$];

  bit no_idle;
  bit hold_request;
  bit hold_started;
  int hold_left;
  int errors;
  int blocks_sent;
  int words_checked;
  int key_writes;

  chacha20_keystream_generator #(
    .DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_bytes   (in_block_bytes),
    .in_end_of_request(in_end_of_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word),
    .out_valid_bytes  (out_valid_bytes),
    .out_last         (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One keystream block from the current key, counter and nonce
  function automatic ks_state_t chacha_block();
    ks_state_t start_s;
    ks_state_t s;
    int ia;
    int ib;
    int ic;
    int id;
    start_s[0] = EXPAND_0;
    start_s[1] = EXPAND_1;
    start_s[2] = EXPAND_2;
    start_s[3] = EXPAND_3;
    for (int i = 0; i < 8; i++) start_s[4 + i] = key_model[i];
    start_s[12] = ctr_model;
    start_s[13] = nonce_model[0];
    start_s[14] = nonce_model[1];
    start_s[15] = nonce_model[2];
    s = start_s;
    for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
      // quarter rounds 0..3 work on columns, 4..7 on diagonals
      for (int q = 0; q < 8; q++) begin
        if (q < 4) begin
          ia = q; ib = q + 4; ic = q + 8; id = q + 12;
        end else begin
          ia = q - 4; ib = 4 + (q - 3) % 4; ic = 8 + (q - 2) % 4; id = 12 + (q - 1) % 4;
        end
        s[ia] = s[ia] + s[ib]; s[id] = s[id] ^ s[ia]; s[id] = (s[id] << 16) | (s[id] >> 16);
        s[ic] = s[ic] + s[id]; s[ib] = s[ib] ^ s[ic]; s[ib] = (s[ib] << 12) | (s[ib] >> 20);
        s[ia] = s[ia] + s[ib]; s[id] = s[id] ^ s[ia]; s[id] = (s[id] << 8) | (s[id] >> 24);
        s[ic] = s[ic] + s[id]; s[ib] = s[ib] ^ s[ic]; s[ib] = (s[ib] << 7) | (s[ib] >> 25);
      end
    end
    for (int i = 0; i < 16; i++) s[i] = s[i] + start_s[i];
    return s;
  endfunction

  // Expected words for one accepted block request, then counter/nonce update
  function automatic void predict_block(bit [6:0] req, bit eor);
    ks_state_t blk;
    int want;
    int nwords;
    int vb;
    ks_word_t w;
    want = (req > MAX_WANT) ? MAX_WANT : req;
    blk = chacha_block();
    nwords = (want + 3) / 4;
    for (int k = 0; k < nwords; k++) begin
      vb = (want - 4 * k > 4) ? 4 : want - 4 * k;
      w.word = blk[k];
      if (vb < 4) w.word = w.word & ((32'h1 << (8 * vb)) - 32'h1);
      w.nbytes = vb[2:0];
      w.last = (k + 1 == nwords);
      expected_words.push_back(w);
    end
    if (eor) begin
      ctr_model = '0;
      nonce_model[0] = nonce_model[0] + 1;
      if (nonce_model[0] == 0) begin
        nonce_model[1] = nonce_model[1] + 1;
        if (nonce_model[1] == 0) nonce_model[2] = nonce_model[2] + 1;
      end
    end else begin
      ctr_model = ctr_model + 1;
    end
  endfunction

  // Sender: offers queued block requests, idling at random
  always @(posedge clk) begin : sender
    block_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_block(in_block_bytes, in_end_of_request);
        blocks_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_blocks.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_blocks.pop_front();
          in_valid <= 1'b1;
          in_block_bytes <= nxt.nbytes;
          in_end_of_request <= nxt.eor;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: scores each word, stalls at random and once for a long stretch
  always @(posedge clk) begin : receiver
    ks_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word %h arrived with nothing expected", $time, out_word);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (out_word !== exp_w.word) begin
            $display("%0t: word expected %h got %h", $time, exp_w.word, out_word);
            errors++;
          end
          if (out_valid_bytes !== exp_w.nbytes) begin
            $display("%0t: valid_bytes expected %0d got %0d", $time, exp_w.nbytes,
                     out_valid_bytes);
            errors++;
          end
          if (out_last !== exp_w.last) begin
            $display("%0t: last expected %0d got %0d", $time, exp_w.last, out_last);
            errors++;
          end
        end
      end
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic queue_block(input bit [6:0] nbytes, input bit eor);
    block_req_t r;
    r.nbytes = nbytes;
    r.eor = eor;
    pending_blocks.push_back(r);
  endtask

  // Random request: mostly 1..64 bytes, some empty and some oversize
  task automatic queue_random(input int count);
    int pick;
    bit [6:0] nb;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) nb = 7'd0;
      else if (pick < 14) nb = 7'($urandom_range(127, 65));
      else nb = 7'($urandom_range(64, 1));
      queue_block(nb, $urandom_range(99) < 25);
    end
  endtask

  // Block idle: all requests taken, all words seen, and time for empty blocks to clear
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_blocks.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bit [1:0] idx, input bit [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    key_writes++;
  endtask

  task automatic load_key(input bit [255:0] k);
    write_reg(REG_KEY_01, k[63:0]);
    write_reg(REG_KEY_23, k[127:64]);
    write_reg(REG_KEY_45, k[191:128]);
    write_reg(REG_KEY_67, k[255:192]);
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 8; i++) key_model[i] = k[32 * i +: 32];
  endtask

  function automatic bit [255:0] random_key();
    bit [255:0] k;
    for (int i = 0; i < 8; i++) k[32 * i +: 32] = $urandom;
    return k;
  endfunction

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset key of all zeros
    queue_block(7'd64, 1'b0);
    queue_block(7'd1, 1'b0);
    queue_block(7'd0, 1'b0);
    queue_block(7'd127, 1'b1);
    queue_block(7'd3, 1'b0);
    wait_drained();

    // directed, byte-counting key 00 01 .. 1f
    load_key(256'h1f1e1d1c_1b1a1918_17161514_13121110_0f0e0d0c_0b0a0908_07060504_03020100);
    queue_block(7'd64, 1'b0);
    queue_block(7'd2, 1'b0);
    queue_block(7'd5, 1'b1);
    queue_block(7'd0, 1'b1);
    queue_block(7'd65, 1'b0);
    queue_block(7'd4, 1'b0);
    queue_block(7'd63, 1'b1);
    queue_block(7'd32, 1'b0);
    queue_block(7'd96, 1'b1);
    queue_block(7'd8, 1'b0);
    wait_drained();

    // all-ones key; receiver holds off so the request path backs up
    load_key({256{1'b1}});
    queue_random(80);
    hold_request = 1'b1;
    wait_drained();

    // random key, no idling on either side
    load_key(random_key());
    no_idle = 1'b1;
    queue_random(75);
    wait_drained();
    no_idle = 1'b0;

    // another random key, normal idling
    load_key(random_key());
    queue_random(75);
    wait_drained();

    $display("run covered %0d block requests over %0d key register writes, %0d words checked",
             blocks_sent, key_writes, words_checked);
    if (errors == 0) begin
      $display("[chacha20_keystream_generator] OK");
    end else begin
      $display("[chacha20_keystream_generator] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[chacha20_keystream_generator] ERROR");
    $finish;
  end

endmodule

// File: chacha20_keystream_generator.f
design/ccks_pkg.sv
design/ccks_queue.sv
design/ccks_front.sv
design/ccks_core.sv
design/chacha20_keystream_generator.sv
bench/testbench.sv
